/* hdl/cse_pkg.sv */
package cse_pkg;

  localparam int unsigned WORD_BITS         = 64;
  localparam int unsigned BYTE_BITS         = 8;
  localparam int unsigned START_BITS        = 6;
  localparam int unsigned LEN_BITS          = 7;
  localparam int unsigned SCALE_BITS        = 32;
  localparam int unsigned HALF_BITS         = 32;
  // raw (64b signed) * scale (32b signed) + offset fits in 97 bits, keep one spare
  localparam int unsigned SUM_BITS          = 98;
  localparam int unsigned PAYLOAD_BYTES_DEF = 8;
  localparam int unsigned MID_DEPTH_DEF     = 4;
  localparam int unsigned OUT_DEPTH_DEF     = 4;

  // Decoded signal waiting between front and back
  typedef struct packed {
    logic signed [WORD_BITS-1:0]  raw;
    logic signed [SCALE_BITS-1:0] scale;
    logic signed [WORD_BITS-1:0]  offset;
    logic signed [WORD_BITS-1:0]  lower;
    logic signed [WORD_BITS-1:0]  upper;
  } cse_item_t;

endpackage

/* hdl/cse_queue.sv */
module cse_queue #(
  parameter int unsigned WIDTH = cse_pkg::WORD_BITS,
  parameter int unsigned DEPTH = cse_pkg::OUT_DEPTH_DEF,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic [CntW-1:0]  count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             wr_en;
  logic             rd_en;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];
  assign wr_en   = wr_i && !full_o;
  assign rd_en   = rd_i && !empty_o;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the written item
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef NO_ASSERTIONS
  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(DEPTH);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("queue overfilled");

  property p_count_up;
    @(posedge clk_i) disable iff (!rst_ni)
      (wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1);
  endproperty
  a_count_up: assert property (p_count_up) else $error("queue count missed a write");

  property p_count_down;
    @(posedge clk_i) disable iff (!rst_ni)
      (rd_en && !wr_en) |=> (count_q == $past(count_q) - 1'b1);
  endproperty
  a_count_down: assert property (p_count_down) else $error("queue count missed a read");
`endif

endmodule

/* hdl/cse_front.sv */
module cse_front #(
  parameter int unsigned PAYLOAD_BYTES = cse_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic [cse_pkg::WORD_BITS-1:0]         frame_payload_i,
  input  logic [cse_pkg::START_BITS-1:0]        field_start_i,
  input  logic [cse_pkg::LEN_BITS-1:0]          field_length_i,
  input  logic                                  is_twos_complement_i,
  input  logic signed [cse_pkg::SCALE_BITS-1:0] scale_q16_i,
  input  logic signed [cse_pkg::WORD_BITS-1:0]  offset_q16_i,
  input  logic signed [cse_pkg::WORD_BITS-1:0]  lower_limit_q16_i,
  input  logic signed [cse_pkg::WORD_BITS-1:0]  upper_limit_q16_i,
  output cse_pkg::cse_item_t                    item_o
);
  import cse_pkg::*;

  localparam int unsigned LimitBits = PAYLOAD_BYTES * BYTE_BITS;

  logic [LEN_BITS-1:0]   len_sat;
  logic [WORD_BITS-1:0]  payload_mask;
  logic [WORD_BITS-1:0]  len_mask;
  logic [WORD_BITS-1:0]  shifted;
  logic [WORD_BITS-1:0]  field;
  logic [START_BITS-1:0] sign_idx;
  logic                  do_ext;

  // Cut the field out of the payload and, for two's complement, sign-extend it
  always_comb begin
    len_sat = (field_length_i > LEN_BITS'(WORD_BITS)) ? LEN_BITS'(WORD_BITS)
                                                      : field_length_i;
    for (int i = 0; i < WORD_BITS; i++) begin
      payload_mask[i] = (i < LimitBits);
      len_mask[i]     = (LEN_BITS'(i) < len_sat);
    end
    shifted  = (frame_payload_i & payload_mask) >> field_start_i;
    field    = shifted & len_mask;
    sign_idx = START_BITS'(len_sat - 1'b1);
    do_ext   = is_twos_complement_i && (len_sat != '0) &&
               (len_sat < LEN_BITS'(WORD_BITS)) && field[sign_idx];
    item_o.raw    = do_ext ? (field | ~len_mask) : field;
    item_o.scale  = scale_q16_i;
    item_o.offset = offset_q16_i;
    item_o.lower  = lower_limit_q16_i;
    item_o.upper  = upper_limit_q16_i;
  end

endmodule

/* hdl/cse_back.sv */
module cse_back #(
  parameter int unsigned OUT_DEPTH = cse_pkg::OUT_DEPTH_DEF,
  localparam int unsigned CntW = $clog2(OUT_DEPTH + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 mid_valid_i,
  input  cse_pkg::cse_item_t                   item_i,
  output logic                                 mid_pop_o,
  input  logic [CntW-1:0]                      out_count_i,
  output logic                                 out_wr_o,
  output logic signed [cse_pkg::WORD_BITS-1:0] out_data_o
);
  import cse_pkg::*;

  localparam int unsigned CreditW = CntW + 1;
  localparam int unsigned PloBits = HALF_BITS + 1 + SCALE_BITS;

  logic                        issue;
  logic [CreditW-1:0]          used;

  logic                        v1_q;
  logic signed [WORD_BITS-1:0] p_hi_q;
  logic signed [PloBits-1:0]   p_lo_q;
  logic signed [WORD_BITS-1:0] offset1_q, lower1_q, upper1_q;

  logic                        v2_q;
  logic signed [SUM_BITS-1:0]  sum_q;
  logic signed [WORD_BITS-1:0] lower2_q, upper2_q;

  logic                        above;
  logic                        below;
  logic                        inverted;

  // Issue only when the result queue has room for everything in flight
  assign used      = CreditW'(out_count_i) + CreditW'(v1_q) + CreditW'(v2_q);
  assign issue     = mid_valid_i && (used < CreditW'(OUT_DEPTH));
  assign mid_pop_o = issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  // Stage 1: two half-width partial products
  always_ff @(posedge clk_i) begin
    if (issue) begin
      p_hi_q    <= $signed(item_i.raw[WORD_BITS-1:HALF_BITS]) * item_i.scale;
      p_lo_q    <= $signed({1'b0, item_i.raw[HALF_BITS-1:0]}) * item_i.scale;
      offset1_q <= item_i.offset;
      lower1_q  <= item_i.lower;
      upper1_q  <= item_i.upper;
    end
  end

  // Stage 2: combine partials and add offset
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      sum_q    <= (SUM_BITS'(p_hi_q) <<< HALF_BITS) + SUM_BITS'(p_lo_q)
                  + SUM_BITS'(offset1_q);
      lower2_q <= lower1_q;
      upper2_q <= upper1_q;
    end
  end

  // Clamp: upper first, then lower wins
  always_comb begin
    above    = sum_q > SUM_BITS'(upper2_q);
    below    = SUM_BITS'(lower2_q) > sum_q;
    inverted = lower2_q > upper2_q;
    if (above) begin
      out_data_o = inverted ? lower2_q : upper2_q;
    end else if (below) begin
      out_data_o = lower2_q;
    end else begin
      out_data_o = sum_q[WORD_BITS-1:0];
    end
  end

  assign out_wr_o = v2_q;

`ifndef NO_ASSERTIONS
  property p_room;
    @(posedge clk_i) disable iff (!rst_ni) v2_q |-> (out_count_i < CntW'(OUT_DEPTH));
  endproperty
  a_room: assert property (p_room) else $error("result written into full queue");

  property p_advance;
    @(posedge clk_i) disable iff (!rst_ni) v1_q |=> v2_q;
  endproperty
  a_advance: assert property (p_advance) else $error("item lost between stages");

  property p_in_limits;
    @(posedge clk_i) disable iff (!rst_ni)
      (v2_q && !inverted) |-> (out_data_o >= lower2_q && out_data_o <= upper2_q);
  endproperty
  a_in_limits: assert property (p_in_limits) else $error("result outside limits");
`endif

endmodule

/* hdl/can_signal_extract_scale.sv */
// Channel  Direction  Handshake            Payload
// input    in         push / full          frame_payload_i .. upper_limit_q16_i
// result   out        empty / pop          physical_q16_o
//
// One item per cycle sustained while pop keeps up; a result shows on the result
// ports once it has passed front to decode queue, product stage and sum stage.
// Rate is set by the two 32-bit partial-product multipliers, one item each cycle.
// Reset clears both queues and the pipeline valid bits; nothing else is held.
// When pop stays low the result queue fills, the back stops issuing, the
// decode queue fills and full rises; no item is dropped.
module can_signal_extract_scale #(
  parameter int unsigned PAYLOAD_BYTES = cse_pkg::PAYLOAD_BYTES_DEF,
  parameter int unsigned MID_DEPTH     = cse_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH     = cse_pkg::OUT_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic [cse_pkg::WORD_BITS-1:0]         frame_payload_i,
  input  logic [cse_pkg::START_BITS-1:0]        field_start_i,
  input  logic [cse_pkg::LEN_BITS-1:0]          field_length_i,
  input  logic                                  is_twos_complement_i,
  input  logic signed [cse_pkg::SCALE_BITS-1:0] scale_q16_i,
  input  logic signed [cse_pkg::WORD_BITS-1:0]  offset_q16_i,
  input  logic signed [cse_pkg::WORD_BITS-1:0]  lower_limit_q16_i,
  input  logic signed [cse_pkg::WORD_BITS-1:0]  upper_limit_q16_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [cse_pkg::WORD_BITS-1:0]  physical_q16_o
);
  import cse_pkg::*;

  localparam int unsigned OutCntW = $clog2(OUT_DEPTH + 1);

  cse_item_t                   front_item;
  cse_item_t                   mid_item;
  logic                        mid_empty;
  logic                        mid_pop;
  logic [OutCntW-1:0]          out_count;
  logic                        out_wr;
  logic signed [WORD_BITS-1:0] out_data;

  // Decode the field
  cse_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .frame_payload_i      (frame_payload_i),
    .field_start_i        (field_start_i),
    .field_length_i       (field_length_i),
    .is_twos_complement_i (is_twos_complement_i),
    .scale_q16_i          (scale_q16_i),
    .offset_q16_i         (offset_q16_i),
    .lower_limit_q16_i    (lower_limit_q16_i),
    .upper_limit_q16_i    (upper_limit_q16_i),
    .item_o               (front_item)
  );

  // Hold decoded items between front and back
  cse_queue #(
    .WIDTH($bits(cse_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_item),
    .full_o  (full),
    .rd_i    (mid_pop),
    .rdata_o (mid_item),
    .empty_o (mid_empty),
    .count_o ()
  );

  // Scale, offset and clamp
  cse_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (!mid_empty),
    .item_i      (mid_item),
    .mid_pop_o   (mid_pop),
    .out_count_i (out_count),
    .out_wr_o    (out_wr),
    .out_data_o  (out_data)
  );

  // Hold results until popped
  cse_queue #(
    .WIDTH(WORD_BITS),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (out_wr),
    .wdata_i (out_data),
    .full_o  (),
    .rd_i    (pop),
    .rdata_o (physical_q16_o),
    .empty_o (empty),
    .count_o (out_count)
  );

endmodule
